>>> rtl/core/ile_pkg.sv
// Shared types and constants for the indexed list engine.
package ile_pkg;

  localparam int ILE_CAPACITY = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  // Compare width: holds any position and any count up to the largest capacity.
  localparam int CMP_W        = 7;

  localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_FWD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_REV = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT,
    OP_DELETE,
    OP_READ_FWD,
    OP_READ_REV,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

endpackage

>>> rtl/core/ile_if.sv
// Request and response channel interfaces of the indexed list engine.
interface ile_req_if;
  import ile_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

interface ile_rsp_if;
  import ile_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, data, status, last, input ready);
  modport sink   (input valid, data, status, last, output ready);
endinterface

>>> rtl/core/ile_front.sv
// Front end: accepts requests, decodes the kind and queues them for the back end.
module ile_front (
  input  logic          clk,
  input  logic          rst,
  ile_req_if.sink       req,
  output ile_pkg::req_t q_item,
  output logic          q_valid,
  input  logic          q_pop
);
  import ile_pkg::*;

  localparam int QD = 2;

  req_t       slots [QD];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  req_t       decoded;

  always_comb begin
    decoded.value    = req.value;
    decoded.position = req.position;
    unique case (req.kind)
      KIND_APPEND:   decoded.op = OP_APPEND;
      KIND_INSERT:   decoded.op = OP_INSERT;
      KIND_DELETE:   decoded.op = OP_DELETE;
      KIND_READ_FWD: decoded.op = OP_READ_FWD;
      KIND_READ_REV: decoded.op = OP_READ_REV;
      default:       decoded.op = OP_BAD;
    endcase
  end

  assign req.ready = (fill != 2'(QD));
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/core/ile_back.sv
// Back end: shifting list cells, edit status and read-out sequencing.
module ile_back #(
  parameter int CAPACITY = ile_pkg::ILE_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  ile_pkg::req_t q_item,
  input  logic          q_valid,
  output logic          q_pop,
  ile_rsp_if.source     rsp
);
  import ile_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                   state;
  logic [CW-1:0]            count;
  logic [IW-1:0]            k;
  logic                     rev;
  logic signed [DATA_W-1:0] cells      [CAPACITY];
  logic signed [DATA_W-1:0] cells_next [CAPACITY];

  logic             out_free;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] ins_pos;
  logic             is_ins;
  logic             is_read;
  logic             ins_range;
  logic             is_full;
  logic             del_range;
  logic             do_ins;
  logic             do_del;
  logic             emit;
  logic [CW-1:0]    count_m1;
  logic [IW-1:0]    rd_idx;
  logic             rd_last;

  always_comb begin
    out_free  = !rsp.valid || rsp.ready;
    q_pop     = q_valid && out_free && (state == S_IDLE);
    count_ext = CMP_W'(count);
    pos_ext   = CMP_W'(q_item.position);
    is_ins    = (q_item.op == OP_APPEND) || (q_item.op == OP_INSERT);
    is_read   = (q_item.op == OP_READ_FWD) || (q_item.op == OP_READ_REV);
    ins_pos   = (q_item.op == OP_APPEND) ? count_ext : pos_ext;
    ins_range = ins_pos > count_ext;
    is_full   = count_ext >= CMP_W'(CAPACITY);
    del_range = pos_ext >= count_ext;
    do_ins    = q_pop && is_ins && !ins_range && !is_full;
    do_del    = q_pop && (q_item.op == OP_DELETE) && !del_range;
    // A response transaction is loaded this cycle
    emit      = (state == S_READ) ? out_free : (q_pop && !(is_read && count != '0));
    count_m1  = count - CW'(1);
    rd_idx    = rev ? IW'(count_m1 - CW'(k)) : k;
    rd_last   = (CW'(k) + CW'(1)) == count;
  end

  // Insert shifts the cells above the slot up; delete, from the slot on, down.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] dn;
    if (i == 0) begin : g_head
      assign up = cells[i];
    end else begin : g_mid_up
      assign up = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign dn = cells[i];
    end else begin : g_mid_dn
      assign dn = cells[i+1];
    end
    assign cells_next[i] = do_ins ? ((IDX == ins_pos) ? q_item.value :
                                     (IDX > ins_pos)  ? up : cells[i]) :
                           (do_del && IDX >= pos_ext) ? dn : cells[i];
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      rev       <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !emit) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_item.op)
              OP_APPEND, OP_INSERT: begin
                rsp.valid  <= 1'b1;
                rsp.data   <= '0;
                rsp.last   <= 1'b1;
                rsp.status <= ins_range ? ST_RANGE : (is_full ? ST_FULL : ST_OK);
                if (do_ins) begin
                  count <= count + CW'(1);
                end
              end
              OP_DELETE: begin
                rsp.valid  <= 1'b1;
                rsp.data   <= '0;
                rsp.last   <= 1'b1;
                rsp.status <= del_range ? ST_RANGE : ST_OK;
                if (do_del) begin
                  count <= count - CW'(1);
                end
              end
              OP_READ_FWD, OP_READ_REV: begin
                if (count == '0) begin
                  rsp.valid  <= 1'b1;
                  rsp.data   <= '0;
                  rsp.last   <= 1'b1;
                  rsp.status <= ST_EMPTY;
                end else begin
                  state <= S_READ;
                  k     <= '0;
                  rev   <= (q_item.op == OP_READ_REV);
                end
              end
              default: begin
                rsp.valid  <= 1'b1;
                rsp.data   <= '0;
                rsp.last   <= 1'b1;
                rsp.status <= ST_RANGE;
              end
            endcase
          end
        end
        S_READ: begin
          // Emit one entry per free output slot; hold otherwise.
          if (out_free) begin
            rsp.valid  <= 1'b1;
            rsp.data   <= cells[rd_idx];
            rsp.status <= ST_OK;
            rsp.last   <= rd_last;
            if (rd_last) begin
              state <= S_IDLE;
            end else begin
              k <= k + IW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/indexed_list_engine_core.sv
// Top level of the indexed list engine: front decode queue feeding the list back end.
//
// A bounded ordered list of signed 32-bit values, up to CAPACITY entries. Requests
// arrive on req and are queued two deep by the front end, so req can stay ready while
// the back end works or while a response waits on rsp. Append, insert and delete each
// shift the list cells in parallel and answer one status transaction. A read-out first
// enters the read state, then emits the entries one per cycle while rsp is free, and
// the back end takes no new request until the last entry is loaded into rsp; an empty
// list answers a single empty_list transaction. The one-entry output register on rsp
// sets the pace whenever the sink stalls. No clearing pass follows reset.
module indexed_list_engine_core #(
  parameter int CAPACITY = ile_pkg::ILE_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  ile_req_if.sink   req,
  ile_rsp_if.source rsp
);
  import ile_pkg::*;

  req_t q_item;
  logic q_valid;
  logic q_pop;

  ile_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  ile_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

>>> sim/tb_indexed_list_engine_core.sv
// Self-checking testbench for indexed_list_engine_core: random and directed list traffic.
module tb_indexed_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;

  localparam int CAP          = ILE_CAPACITY;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 2 * CAP + 20;
  localparam int BATCH        = 8;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIX    = 2;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } list_req_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } list_rsp_t;

  logic clk;
  logic rst;

  ile_req_if req_ch ();
  ile_rsp_if rsp_ch ();

  indexed_list_engine_core #(.CAPACITY(CAP)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];

  // Shadow copy of the list contents
  logic signed [DATA_W-1:0] list_cells [CAP];
  int unsigned              list_len = 0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatch_cnt  = 0;
  int  cycle_cnt     = 0;
  int  hold_left;
  bit  hold_pulse = 0;
  bit  hold_seen;
  bit  req_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- prediction ----------------

  task automatic queue_result(input logic signed [DATA_W-1:0] d,
                              input logic [STATUS_W-1:0] st, input logic lst);
    list_rsp_t r;
    r.data   = d;
    r.status = st;
    r.last   = lst;
    expected_rsps.push_back(r);
  endtask

  function automatic logic [STATUS_W-1:0] list_insert(input int unsigned pos,
                                                      input logic signed [DATA_W-1:0] v);
    int unsigned i;
    // range check wins over the full check
    if (pos > list_len) return ST_RANGE;
    if (list_len >= CAP) return ST_FULL;
    for (i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
    list_cells[pos] = v;
    list_len++;
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] list_delete(input int unsigned pos);
    int unsigned i;
    if (pos >= list_len) return ST_RANGE;
    for (i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
    list_len--;
    return ST_OK;
  endfunction

  task automatic list_readout(input bit reverse);
    int unsigned k;
    int unsigned idx;
    if (list_len == 0) begin
      queue_result('0, ST_EMPTY, 1'b1);
      return;
    end
    for (k = 0; k < list_len; k++) begin
      idx = reverse ? (list_len - 1 - k) : k;
      queue_result(list_cells[idx], ST_OK, (k + 1 == list_len));
    end
  endtask

  task automatic model_request(input list_req_t r);
    case (r.kind)
      KIND_APPEND:   queue_result('0, list_insert(list_len, r.value), 1'b1);
      KIND_INSERT:   queue_result('0, list_insert(r.position, r.value), 1'b1);
      KIND_DELETE:   queue_result('0, list_delete(r.position), 1'b1);
      KIND_READ_FWD: list_readout(1'b0);
      KIND_READ_REV: list_readout(1'b1);
      default:       queue_result('0, ST_RANGE, 1'b1);
    endcase
  endtask

  // ---------------- checking ----------------

  task automatic note_mismatch(input string what, input list_rsp_t want, input list_rsp_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN)
      $display("%0t mismatch (%s): expected data=%0d status=%0d last=%0d, %s",
               $realtime, what, want.data, want.status, want.last,
               $sformatf("got data=%0d status=%0d last=%0d",
                         got.data, got.status, got.last));
  endtask

  task automatic check_result(input list_rsp_t got);
    list_rsp_t want;
    if (expected_rsps.size() == 0) begin
      want.data   = 'x;
      want.status = 'x;
      want.last   = 1'bx;
      note_mismatch("unexpected result", want, got);
      return;
    end
    want = expected_rsps.pop_front();
    if (got.data !== want.data || got.status !== want.status || got.last !== want.last)
      note_mismatch("field", want, got);
  endtask

  always @(posedge clk) begin
    list_rsp_t got;
    list_req_t acc;
    cycle_cnt <= cycle_cnt + 1;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.data   = rsp_ch.data;
        got.status = rsp_ch.status;
        got.last   = rsp_ch.last;
        check_result(got);
      end
      if (req_ch.valid && req_ch.ready) begin
        acc.kind     = req_ch.kind;
        acc.value    = req_ch.value;
        acc.position = req_ch.position;
        model_request(acc);
      end
    end
  end

  // ---------------- driving ----------------

  always @(negedge clk) begin
    list_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        req_ch.kind     <= nxt.kind;
        req_ch.value    <= nxt.value;
        req_ch.position <= nxt.position;
        req_ch.valid    <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response sink; a toggle of hold_pulse starts a long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 1'b0;
    end else if (hold_pulse != hold_seen) begin
      hold_seen    <= hold_pulse;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_req(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v,
                          input logic [POS_W-1:0] p);
    list_req_t r;
    r.kind     = k;
    r.value    = v;
    r.position = p;
    pending_reqs.push_back(r);
  endtask

  // Hold until every queued request has been taken by the block
  task automatic wait_all_sent();
    do @(posedge clk); while (pending_reqs.size() != 0 || req_ch.valid);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom();
    endcase
  endfunction

  function automatic list_req_t pick_request(input int mode, input int unsigned len);
    list_req_t r;
    int r_pick;
    int grow_pct;
    r_pick     = $urandom_range(99);
    r.value    = pick_value();
    r.position = POS_W'($urandom_range(63));
    grow_pct   = (mode == MODE_GROW) ? 70 : (mode == MODE_SHRINK) ? 30 : 50;
    if (r_pick < 4) begin
      r.kind = KIND_W'($urandom_range(5, 7));
    end else if (r_pick < 18) begin
      r.kind = $urandom_range(1) ? KIND_READ_FWD : KIND_READ_REV;
    end else if ($urandom_range(99) < grow_pct) begin
      r.kind = $urandom_range(1) ? KIND_APPEND : KIND_INSERT;
      if (r.kind == KIND_INSERT && $urandom_range(99) < 85)
        r.position = POS_W'($urandom_range(0, len));
    end else begin
      r.kind = KIND_DELETE;
      if ($urandom_range(99) < 85)
        r.position = POS_W'(len > 0 ? $urandom_range(0, len - 1) : 0);
    end
    return r;
  endfunction

  task automatic random_traffic(input int n_items);
    int sent;
    int mode;
    int j;
    list_req_t r;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(MODE_MIX);
      for (j = 0; j < BATCH; j++) begin
        r = pick_request(mode, list_len);
        pending_reqs.push_back(r);
      end
      sent += BATCH;
      wait_all_sent();
    end
  endtask

  task automatic directed_traffic();
    int j;
    int unsigned need;
    send_req(KIND_READ_FWD, '0, '0);          // empty list read-outs
    send_req(KIND_READ_REV, '0, '0);
    send_req(KIND_DELETE, '0, 6'd0);          // delete on empty
    send_req(KIND_INSERT, 32'sd7, 6'd1);      // insert past end
    send_req(KIND_INSERT, VAL_MIN, 6'd0);
    send_req(KIND_APPEND, VAL_MAX, '0);
    send_req(KIND_APPEND, '0, 6'h3f);
    send_req(KIND_APPEND, -32'sd1, 6'h2a);
    send_req(KIND_INSERT, 32'sd5, 6'd4);      // insert at count acts as append
    send_req(KIND_INSERT, 32'sd123, 6'd0);
    send_req(KIND_READ_FWD, '0, '0);
    send_req(KIND_READ_REV, '0, '0);
    send_req(KIND_DELETE, '0, 6'h3f);
    send_req(KIND_INSERT, 32'sh5555_aaaa, 6'h3f);
    send_req(KIND_DELETE, '0, 6'd5);          // drop tail
    send_req(KIND_DELETE, '0, 6'd0);          // drop head
    send_req(3'd5, VAL_MAX, 6'h15);
    send_req(3'd6, VAL_MIN, 6'h2a);
    send_req(3'd7, -32'sd1, 6'h3f);
    for (j = 0; j < 3; j++) send_req(KIND_DELETE, '0, 6'd0);
    send_req(KIND_READ_FWD, '0, '0);          // single entry
    send_req(KIND_DELETE, '0, 6'd0);          // single-element delete
    send_req(KIND_READ_REV, '0, '0);
    wait_all_sent();

    // fill to capacity, then hit the full and out-of-range cases
    need = CAP - list_len;
    for (j = 0; j < need; j++) send_req(KIND_APPEND, pick_value(), POS_W'($urandom()));
    send_req(KIND_APPEND, 32'sd9, '0);
    send_req(KIND_INSERT, 32'sd9, 6'd0);
    send_req(KIND_INSERT, 32'sd9, POS_W'(CAP));
    send_req(KIND_INSERT, 32'sd9, POS_W'(CAP + 1));
    send_req(KIND_READ_FWD, '0, '0);
    send_req(KIND_READ_REV, '0, '0);
    wait_all_sent();
  endtask

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 17;
    recv_idle_pct = 75;
    directed_traffic();
    random_traffic(48);

    send_idle_pct = 75;
    recv_idle_pct = 17;
    random_traffic(48);

    // stall the sink for a long stretch while requests keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_pulse = ~hold_pulse;
    random_traffic(40);

    wait_all_sent();
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             expected_rsps.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ile_pkg.sv
rtl/core/ile_if.sv
rtl/core/ile_front.sv
rtl/core/ile_back.sv
rtl/core/indexed_list_engine_core.sv
sim/tb_indexed_list_engine_core.sv
